// ===== hw/rtl/garch_pkg.sv =====
// Shared types and constants for the GARCH volatility recursion block.
// No dependencies.
`default_nettype none
package garch_pkg;

    localparam int unsigned HIST_DEPTH = 3;
    localparam int unsigned CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARCH_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARCH_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GARCH_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GARCH_3 = 3'd6;

    localparam logic ACTION_PRIME = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQRT,
        ST_MUL,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture input item
        logic       prime;    // shift start values into history
        logic       mac_go;   // one multiply-accumulate term
        logic [2:0] term;     // term index 0..5
        logic       sqrt_init;
        logic       sqrt_go;
        logic       mul_go;   // volatility times residual, shift history
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/garch_volatility_recursion.sv =====
// GARCH(3,3) volatility recursion: a step runs the multiply-accumulate (6 terms on
// one shared square stage, the last term added after its square), then 32 root bits
// one per cycle, one return multiply and the output load; the next item is taken in
// the cycle after the output load, not before the last result is loaded.
// A prime item gives no result; a held result stalls the next step.
// Reset (rst_n, async low) clears history, config registers and control.
`default_nettype none
module garch_volatility_recursion #(
    parameter int unsigned ARCH_ORDER  = 3,
    parameter int unsigned GARCH_ORDER = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_idx,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // start_return, start_volatility, innovation
    input  wire logic          s_tuser,   // action
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata    // sim_return, sim_volatility
);

    garch_pkg::dp_cmd_t cmd;
    logic idle, out_load, in_fire, out_fire;
    logic [31:0] res_return, res_vol;
    logic m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid_reg && m_tready;

    garch_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_action(s_tuser),
        .out_busy(m_tvalid_reg), .out_fire(out_fire), .idle(idle),
        .out_load(out_load), .cmd(cmd)
    );

    garch_dp #(.ARCH_ORDER(ARCH_ORDER), .GARCH_ORDER(GARCH_ORDER)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_return(s_tdata[31:0]), .in_vol(s_tdata[63:32]),
        .in_innov(s_tdata[95:64]), .cmd(cmd), .res_return(res_return),
        .res_vol(res_vol)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (out_fire)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {res_vol, res_return};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/garch_ctrl.sv =====
// Controller state machine for the GARCH recursion.
// Depends on garch_pkg.
`default_nettype none
module garch_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic                in_action,
    input  wire logic                out_busy,
    input  wire logic                out_fire,
    output logic                     idle,
    output logic                     out_load,
    output garch_pkg::dp_cmd_t       cmd
);

    garch_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            garch_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && in_action == garch_pkg::ACTION_STEP)
                    state_next = garch_pkg::ST_MAC;
            end
            garch_pkg::ST_MAC:
            begin
                // one square per term for six terms, the last term is added in the cycle after
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd6)
                begin
                    cnt_next   = '0;
                    state_next = garch_pkg::ST_SQRT;
                end
            end
            garch_pkg::ST_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = garch_pkg::ST_MUL;
            end
            garch_pkg::ST_MUL:
                state_next = garch_pkg::ST_OUT;
            garch_pkg::ST_OUT:
                if (!out_busy || out_fire)
                    state_next = garch_pkg::ST_IDLE;
            default:
                state_next = garch_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        idle      = 1'b0;
        out_load  = 1'b0;
        cmd.term  = cnt_reg[2:0];
        case (state_reg)
            garch_pkg::ST_IDLE:
            begin
                idle          = 1'b1;
                cmd.load      = in_fire;
                cmd.prime     = in_fire && in_action == garch_pkg::ACTION_PRIME;
            end
            garch_pkg::ST_MAC:
            begin
                cmd.mac_go    = cnt_reg != 5'd6;
                cmd.sqrt_init = cnt_reg == 5'd6;
            end
            garch_pkg::ST_SQRT:
                cmd.sqrt_go   = 1'b1;
            garch_pkg::ST_MUL:
                cmd.mul_go    = 1'b1;
            garch_pkg::ST_OUT:
                out_load      = !out_busy || out_fire;
            default:
                idle          = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= garch_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a result is only loaded out of the output state
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> $past(state_reg) == garch_pkg::ST_OUT || state_reg == garch_pkg::ST_OUT)
        else $error("out_load outside output state");
    a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == garch_pkg::ST_MUL) |-> $past(state_reg) == garch_pkg::ST_SQRT)
        else $error("multiply entered without root");
    a_mac_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == garch_pkg::ST_MAC) |-> cnt_reg <= 5'd6)
        else $error("term counter overrun");

endmodule
`default_nettype wire

// ===== hw/rtl/garch_dp.sv =====
// Datapath: history, config, shared multiply-accumulate, bit-serial root, return.
// Depends on garch_pkg.
`default_nettype none
module garch_dp #(
    parameter int unsigned ARCH_ORDER  = 3,
    parameter int unsigned GARCH_ORDER = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_idx,
    input  wire logic [31:0]        cfg_data,
    input  wire logic [31:0]        in_return,
    input  wire logic [31:0]        in_vol,
    input  wire logic [31:0]        in_innov,
    input  garch_pkg::dp_cmd_t      cmd,
    output logic [31:0]             res_return,
    output logic [31:0]             res_vol
);

    logic [31:0] omega_reg;
    logic [15:0] arch_reg [garch_pkg::HIST_DEPTH];
    logic [15:0] garch_reg [garch_pkg::HIST_DEPTH];
    logic [31:0] rh_reg [garch_pkg::HIST_DEPTH];
    logic [31:0] vh_reg [garch_pkg::HIST_DEPTH];
    logic [31:0] innov_reg;
    logic [64:0] acc_reg, acc_next;
    logic [63:0] rem_reg;
    logic [31:0] root_reg, ret_sat;
    logic [63:0] sq_reg;
    logic [15:0] coef_reg;
    logic        used_reg;
    logic [1:0]  k;
    logic        is_vol, used;
    logic [31:0] hval, mag;
    logic [15:0] coef;
    logic [63:0] sq;
    logic [79:0] wt;
    logic [65:0] trial;
    logic [31:0] rmag;
    logic [63:0] prod;
    logic [47:0] q;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                arch_reg[i]  <= '0;
                garch_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_idx == garch_pkg::REG_OMEGA)
                omega_reg <= cfg_data;
            else if (cfg_idx >= garch_pkg::REG_ARCH_1 && cfg_idx <= garch_pkg::REG_ARCH_3)
                arch_reg[2'(cfg_idx - garch_pkg::REG_ARCH_1)] <= cfg_data[15:0];
            else if (cfg_idx >= garch_pkg::REG_GARCH_1 && cfg_idx <= garch_pkg::REG_GARCH_3)
                garch_reg[2'(cfg_idx - garch_pkg::REG_GARCH_1)] <= cfg_data[15:0];
        end
    end

    // term select: terms 0..2 returns, 3..5 volatilities; coef k with entry 3-order+k
    always_comb
    begin
        is_vol = cmd.term >= 3'd3;
        k      = is_vol ? 2'(cmd.term - 3'd3) : cmd.term[1:0];
        used   = is_vol ? (32'(k) < GARCH_ORDER) : (32'(k) < ARCH_ORDER);
        hval   = is_vol ? vh_reg[2'(32'(k) + 3 - GARCH_ORDER)]
                        : rh_reg[2'(32'(k) + 3 - ARCH_ORDER)];
        coef   = is_vol ? garch_reg[k] : arch_reg[k];
        mag    = (!is_vol && hval[31]) ? 32'(0) - hval : hval;
    end
    assign sq = 64'(mag) * 64'(mag);

    // square stage: the weighted term is added in the cycle after its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg   <= '0;
            coef_reg <= '0;
            used_reg <= 1'b0;
        end
        else
        begin
            sq_reg   <= sq;
            coef_reg <= coef;
            used_reg <= cmd.mac_go && used;
        end
    end

    assign wt = 80'(sq_reg) * 80'(coef_reg);

    always_comb
    begin
        acc_next = acc_reg + 65'(wt[79:16]);
        if (acc_next[64])
            acc_next = {1'b0, {64{1'b1}}};
    end

    // restoring root, one result bit per cycle
    assign trial  = {rem_reg, acc_reg[63:62]} - {32'd0, root_reg, 2'b01};

    assign rmag = innov_reg[31] ? 32'(0) - innov_reg : innov_reg;
    assign prod = 64'(root_reg) * 64'(rmag);
    assign q    = prod[63:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rh_reg[i] <= '0;
                vh_reg[i] <= '0;
            end
        end
        else if (cmd.prime || cmd.mul_go)
        begin
            rh_reg[0] <= rh_reg[1];
            rh_reg[1] <= rh_reg[2];
            vh_reg[0] <= vh_reg[1];
            vh_reg[1] <= vh_reg[2];
            rh_reg[2] <= cmd.prime ? in_return : ret_sat;
            vh_reg[2] <= cmd.prime ? in_vol : root_reg;
        end
    end

    always_comb
    begin
        ret_sat = '0;
        if (innov_reg[31])
            ret_sat = (q > 48'h8000_0000) ? 32'h8000_0000 : 32'(0) - q[31:0];
        else
            ret_sat = (q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            innov_reg <= in_innov;
            acc_reg   <= {1'b0, omega_reg, 16'd0};
        end
        else if (cmd.sqrt_go)
        begin
            acc_reg <= {acc_reg[64], acc_reg[61:0], 2'b00};
            if (!trial[65])
            begin
                rem_reg  <= trial[63:0];
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[61:0], acc_reg[63:62]};
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
        else if (used_reg)
            acc_reg <= acc_next;
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.mul_go)
        begin
            res_return <= ret_sat;
            res_vol    <= root_reg;
        end
    end

endmodule
`default_nettype wire
